/* rtl/max_flow_edmonds_karp_assert.svh */
// ----------------------------------------------------------------------------
// Assertion macros for the max flow block
// Clocked on clk; the first form is held off during rst.
// ----------------------------------------------------------------------------
`ifndef MAX_FLOW_EDMONDS_KARP_ASSERT_SVH
`define MAX_FLOW_EDMONDS_KARP_ASSERT_SVH

`define MFEK_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

`define MFEK_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

/* rtl/mfek_pkg.sv */
// ----------------------------------------------------------------------------
// mfek_pkg
// Field widths and command codes of the max flow block.
// ----------------------------------------------------------------------------
package mfek_pkg;

  localparam int NODE_FIELD_BITS = 5;
  localparam int CAP_FIELD_BITS  = 16;
  localparam int DIV_BITS        = 16;
  localparam int FLOW_BITS       = 21;
  localparam int IN_DATA_BITS    = 32;
  localparam int IN_USER_BITS    = 2;
  localparam int OUT_DATA_BITS   = 24;

  typedef logic [IN_USER_BITS-1:0] opcode_t;

  localparam opcode_t OP_CLEAR  = 2'd0;
  localparam opcode_t OP_WRITE  = 2'd1;
  localparam opcode_t OP_RUN    = 2'd2;
  localparam opcode_t OP_UNUSED = 2'd3;

endpackage

/* rtl/max_flow_edmonds_karp.sv */
// ----------------------------------------------------------------------------
// max_flow_edmonds_karp
// Capacity matrix store and Edmonds-Karp max flow engine.
// ----------------------------------------------------------------------------
// Input transfers carry a command in s_tuser: clear the capacity matrix,
// write one edge capacity, or run max flow from a source to a sink.
// cfg_we/cfg_wdata set the capacity divisor (reset value 1).
// A write is stored straight from the idle state; a clear sweeps the whole matrix.
// A run gives one result transfer on m_*; the other commands give none.
// A run first builds the residual matrix, each entry passing through the
// bit-serial divider; then each BFS pass scans through the one residual
// read port, and each augmentation updates the path hop by hop.
// After reset the block runs a clearing pass with s_tready low.
// s_tready is high only when the engine is idle.
// The result sits in an output register; loads continue while it waits,
// and a finished run holds until the previous result has been taken.
// ----------------------------------------------------------------------------
module max_flow_edmonds_karp #(
  parameter int NODE_COUNT    = 32,
  parameter int CAPACITY_BITS = 16
) (
  input  logic                                 clk,
  input  logic                                 rst,
  input  logic                                 cfg_we,
  input  logic [mfek_pkg::DIV_BITS-1:0]        cfg_wdata,
  input  logic                                 s_tvalid,
  output logic                                 s_tready,
  // from_node[4:0], to_node[9:5], edge_capacity_value[25:10]
  input  logic [mfek_pkg::IN_DATA_BITS-1:0]    s_tdata,
  // opcode[1:0]
  input  logic [mfek_pkg::IN_USER_BITS-1:0]    s_tuser,
  output logic                                 m_tvalid,
  input  logic                                 m_tready,
  // max_flow[20:0]
  output logic [mfek_pkg::OUT_DATA_BITS-1:0]   m_tdata
);

  import mfek_pkg::*;

  localparam int NW = (NODE_COUNT > 1) ? $clog2(NODE_COUNT) : 1;
  localparam int AW = 2 * NW;
  localparam int MD = NODE_COUNT * NODE_COUNT;
  localparam int CB = CAPACITY_BITS;
  localparam int RB = CB + 1;
  localparam int QW = NW + RB;
  localparam int CW = $clog2(CB);
  localparam logic [NW:0]   N_CNT     = (NW+1)'(NODE_COUNT);
  localparam logic [NW-1:0] NODE_LAST = NW'(NODE_COUNT - 1);
  localparam logic [AW-1:0] ADDR_LAST = AW'(MD - 1);
  localparam logic [CW-1:0] STEP_LAST = CW'(CB - 1);

  typedef enum logic [3:0] {
    S_CLR, S_IDLE, S_INIT_RD, S_INIT_LD, S_DIV, S_INIT_WR, S_BFS, S_POP,
    S_POP_W, S_SCAN, S_AUG_CHK, S_AUG_P, S_AUG_R2, S_AUG_W2, S_DONE
  } state_t;

  state_t state;

  logic [DIV_BITS-1:0]  divisor;
  logic [AW-1:0]        addr;
  logic [NW-1:0]        src, snk, cur, prev, sc_v;
  logic [NW:0]          head, tail, vi, guard;
  logic                 sc_vld;
  logic [RB-1:0]        bound, inc;
  logic [NODE_COUNT-1:0] pv;
  logic [FLOW_BITS-1:0] total;
  logic [CB-1:0]        dvd;
  logic [DIV_BITS:0]    rem;
  logic [CW-1:0]        cnt;

  // memories
  logic [CB-1:0] st_mem [MD];
  logic [RB-1:0] rs_mem [MD];
  logic [NW-1:0] pa_mem [NODE_COUNT];
  logic [QW-1:0] qu_mem [NODE_COUNT];

  logic          st_we;
  logic [AW-1:0] st_wa;
  logic [CB-1:0] st_wd, st_q;
  logic          rs_we;
  logic [AW-1:0] rs_wa, rs_ra;
  logic [RB-1:0] rs_wd, rs_q;
  logic          pa_we;
  logic [NW-1:0] pa_wa, pa_wd, pa_q;
  logic          qu_we;
  logic [NW-1:0] qu_wa;
  logic [QW-1:0] qu_wd, qu_q;

  always_ff @(posedge clk) begin
    if (st_we) st_mem[st_wa] <= st_wd;
    st_q <= st_mem[addr];
  end

  always_ff @(posedge clk) begin
    if (rs_we) rs_mem[rs_wa] <= rs_wd;
    rs_q <= rs_mem[rs_ra];
  end

  always_ff @(posedge clk) begin
    if (pa_we) pa_mem[pa_wa] <= pa_wd;
    pa_q <= pa_mem[cur];
  end

  always_ff @(posedge clk) begin
    if (qu_we) qu_mem[qu_wa] <= qu_wd;
    qu_q <= qu_mem[head[NW-1:0]];
  end

  // input fields
  opcode_t                    op;
  logic [8:0]                 from_ext, to_ext;
  logic                       nodes_ok, s_fire;
  logic [NW-1:0]              from_idx, to_idx;
  logic [CB-1:0]              cap_w;

  assign op       = s_tuser;
  assign from_ext = {4'd0, s_tdata[4:0]};
  assign to_ext   = {4'd0, s_tdata[9:5]};
  assign nodes_ok = (from_ext < 9'(NODE_COUNT)) && (to_ext < 9'(NODE_COUNT));
  assign from_idx = from_ext[NW-1:0];
  assign to_idx   = to_ext[NW-1:0];
  assign cap_w    = CB'(s_tdata[25:10]);
  assign s_tready = (state == S_IDLE);
  assign s_fire   = s_tvalid && s_tready;

  // scan and divider datapath
  logic          take, hit_snk;
  logic [RB-1:0] nb;
  logic [DIV_BITS:0] rem_sh;
  logic          ge;

  assign take    = sc_vld && !pv[sc_v] && (rs_q != '0);
  assign hit_snk = take && (sc_v == snk);
  assign nb      = (bound < rs_q) ? bound : rs_q;
  assign rem_sh  = {rem[DIV_BITS-1:0], dvd[CB-1]};
  assign ge      = rem_sh >= {1'b0, divisor};

  always_comb begin
    st_we = 1'b0;
    st_wa = addr;
    st_wd = '0;
    rs_we = 1'b0;
    rs_wa = addr;
    rs_wd = '0;
    rs_ra = {cur, prev};
    pa_we = 1'b0;
    pa_wa = sc_v;
    pa_wd = cur;
    qu_we = 1'b0;
    qu_wa = tail[NW-1:0];
    qu_wd = {sc_v, nb};
    unique case (state)
      S_CLR: st_we = 1'b1;
      S_IDLE: begin
        if (s_fire && op == OP_WRITE && nodes_ok) begin
          st_we = 1'b1;
          st_wa = {from_idx, to_idx};
          st_wd = cap_w;
        end
      end
      S_INIT_WR: begin
        rs_we = 1'b1;
        rs_wd = (divisor == '0) ? '0 : {1'b0, dvd};
      end
      S_BFS: begin
        qu_we = 1'b1;
        qu_wa = '0;
        qu_wd = {src, {RB{1'b1}}};
      end
      S_SCAN: begin
        rs_ra = {cur, vi[NW-1:0]};
        pa_we = take;
        qu_we = take && !hit_snk && (tail < N_CNT);
      end
      S_AUG_P: rs_ra = {pa_q, cur};
      S_AUG_R2: begin
        rs_we = 1'b1;
        rs_wa = {prev, cur};
        rs_wd = rs_q - inc;
      end
      S_AUG_W2: begin
        rs_we = 1'b1;
        rs_wa = {cur, prev};
        rs_wd = rs_q + inc;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      divisor <= DIV_BITS'(1);
    end else if (cfg_we) begin
      divisor <= cfg_wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= S_CLR;
      addr     <= '0;
      m_tvalid <= 1'b0;
      head     <= '0;
      tail     <= '0;
      pv       <= '0;
      total    <= '0;
      sc_vld   <= 1'b0;
    end else begin
      if (m_tvalid && m_tready && state != S_DONE) m_tvalid <= 1'b0;
      unique case (state)
        S_CLR: begin
          addr <= addr + 1'b1;
          if (addr == ADDR_LAST) state <= S_IDLE;
        end
        S_IDLE: begin
          if (s_fire) begin
            case (op)
              OP_CLEAR: begin
                addr  <= '0;
                state <= S_CLR;
              end
              OP_RUN: begin
                src   <= from_idx;
                snk   <= to_idx;
                total <= '0;
                addr  <= '0;
                if (nodes_ok && from_idx != to_idx) state <= S_INIT_RD;
                else state <= S_DONE;
              end
              default: ;
            endcase
          end
        end
        S_INIT_RD: state <= S_INIT_LD;
        S_INIT_LD: begin
          dvd   <= st_q;
          rem   <= '0;
          cnt   <= '0;
          state <= S_DIV;
        end
        S_DIV: begin
          rem <= ge ? (rem_sh - {1'b0, divisor}) : rem_sh;
          dvd <= {dvd[CB-2:0], ge};
          cnt <= cnt + 1'b1;
          if (cnt == STEP_LAST) state <= S_INIT_WR;
        end
        S_INIT_WR: begin
          addr <= addr + 1'b1;
          if (addr == ADDR_LAST) state <= S_BFS;
          else state <= S_INIT_RD;
        end
        S_BFS: begin
          pv    <= NODE_COUNT'(1) << src;
          head  <= '0;
          tail  <= (NW+1)'(1);
          state <= S_POP;
        end
        S_POP: begin
          if (head == tail) state <= S_DONE;
          else state <= S_POP_W;
        end
        S_POP_W: begin
          cur    <= qu_q[QW-1:RB];
          bound  <= qu_q[RB-1:0];
          head   <= head + 1'b1;
          vi     <= '0;
          sc_vld <= 1'b0;
          state  <= S_SCAN;
        end
        S_SCAN: begin
          if (take) begin
            pv[sc_v] <= 1'b1;
            if (!hit_snk && tail < N_CNT) tail <= tail + 1'b1;
          end
          if (hit_snk) begin
            inc    <= nb;
            total  <= total + FLOW_BITS'(nb);
            cur    <= snk;
            guard  <= '0;
            sc_vld <= 1'b0;
            state  <= S_AUG_CHK;
          end else begin
            if (vi < N_CNT) begin
              vi     <= vi + 1'b1;
              sc_vld <= 1'b1;
              sc_v   <= vi[NW-1:0];
            end else begin
              sc_vld <= 1'b0;
            end
            if (sc_vld && sc_v == NODE_LAST) state <= S_POP;
          end
        end
        S_AUG_CHK: begin
          if (cur == src || guard == N_CNT) state <= S_BFS;
          else state <= S_AUG_P;
        end
        S_AUG_P: begin
          prev  <= pa_q;
          state <= S_AUG_R2;
        end
        S_AUG_R2: state <= S_AUG_W2;
        S_AUG_W2: begin
          cur   <= prev;
          guard <= guard + 1'b1;
          state <= S_AUG_CHK;
        end
        S_DONE: begin
          if (!m_tvalid || m_tready) begin
            m_tvalid <= 1'b1;
            m_tdata  <= {{(OUT_DATA_BITS-FLOW_BITS){1'b0}}, total};
            state    <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

`include "max_flow_edmonds_karp_assert.svh"

  `MFEK_ASSERT(a_head_le_tail, head <= tail, "queue head passed tail")
  `MFEK_ASSERT(a_tail_bound, tail <= N_CNT, "queue tail beyond depth")
  `MFEK_ASSERT(a_src_visited, (state == S_SCAN) |-> pv[src], "source not marked visited")
  `MFEK_ASSERT_ALWAYS(a_out_from_done, $rose(m_tvalid) |-> ($past(state) == S_DONE), "result without finished run")

endmodule

/* dv/max_flow_edmonds_karp_tb.sv */
// ----------------------------------------------------------------------------
// max_flow_edmonds_karp_tb
// Loads capacity graphs, runs max flow under several divisor settings and
// checks each flow against a given value or a BFS augmenting-path predictor.
// ----------------------------------------------------------------------------
module max_flow_edmonds_karp_tb;
  import mfek_pkg::*;

  localparam int NODES = 32;

  typedef struct {
    opcode_t     op;
    logic [4:0]  from_node;
    logic [4:0]  to_node;
    logic [15:0] cap;
    bit          typed;
    logic [20:0] flow;
  } stim_row_t;

  logic        clk;
  logic        rst;
  logic        cfg_we;
  logic [15:0] cfg_wdata;
  logic        s_tvalid;
  logic        s_tready;
  logic [31:0] s_tdata;
  logic [1:0]  s_tuser;
  logic        m_tvalid;
  logic        m_tready;
  logic [23:0] m_tdata;

  logic [15:0] cap_matrix [NODES][NODES];
  logic [15:0] divisor;
  logic [20:0] flow_queue [$];
  int          errors;
  bit          calm;
  bit          hold_req;
  int          runs_sent;

  max_flow_edmonds_karp uut (
    .clk(clk), .rst(rst), .cfg_we(cfg_we), .cfg_wdata(cfg_wdata),
    .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tuser(s_tuser),
    .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata)
  );

  always begin
    clk = 1'b1; #5;
    clk = 1'b0; #5;
  end

  task automatic report(input string what, input logic [20:0] got, input logic [20:0] want);
    $display("mismatch %s: got %0d expected %0d", what, got, want);
    errors++;
  endtask

  function automatic longint find_aug(ref longint res [NODES][NODES], ref int par [NODES],
                                      input int src, input int snk);
    bit     seen [NODES];
    int     q [NODES];
    longint qb [NODES];
    int     head;
    int     tail;
    int     cur;
    longint bound;
    longint nb;
    head = 0;
    tail = 1;
    foreach (seen[i]) seen[i] = 0;
    seen[src] = 1;
    par[src] = src;
    q[0] = src;
    qb[0] = 64'h7fff_ffff_ffff_ffff;
    while (head < tail) begin
      cur = q[head];
      bound = qb[head];
      head++;
      for (int v = 0; v < NODES; v++) begin
        if (!seen[v] && res[cur][v] != 0) begin
          nb = bound < res[cur][v] ? bound : res[cur][v];
          seen[v] = 1;
          par[v] = cur;
          if (v == snk) return nb;
          if (tail < NODES) begin
            q[tail] = v;
            qb[tail] = nb;
            tail++;
          end
        end
      end
    end
    return 0;
  endfunction

  function automatic logic [20:0] predict_flow(input int src, input int snk);
    longint res [NODES][NODES];
    int     par [NODES];
    longint total;
    longint inc;
    int     cur;
    int     guard;
    int     prev;
    total = 0;
    for (int i = 0; i < NODES; i++)
      for (int j = 0; j < NODES; j++)
        res[i][j] = divisor != 0 ? cap_matrix[i][j] / divisor : 0;
    if (src == snk) return 0;
    inc = find_aug(res, par, src, snk);
    while (inc != 0) begin
      total += inc;
      cur = snk;
      guard = 0;
      while (cur != src && guard < NODES) begin
        prev = par[cur];
        res[prev][cur] -= inc;
        res[cur][prev] += inc;
        cur = prev;
        guard++;
      end
      inc = find_aug(res, par, src, snk);
    end
    return total[20:0];
  endfunction

  task automatic send(input opcode_t op, input logic [4:0] f, input logic [4:0] t,
                      input logic [15:0] c, input bit typed = 0,
                      input logic [20:0] flow = '0);
    logic [20:0] p;
    while (!calm && $urandom_range(99) < 28) begin
      s_tvalid <= 1'b0;
      @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tuser  <= op;
    s_tdata  <= {6'b0, c, t, f};
    do @(posedge clk); while (!s_tready);
    case (op)
      OP_CLEAR: foreach (cap_matrix[i, j]) cap_matrix[i][j] = '0;
      OP_WRITE: cap_matrix[f][t] = c;
      OP_RUN: begin
        p = predict_flow(f, t);
        flow_queue = {flow_queue, typed ? flow : p};
        runs_sent++;
      end
      default: ;
    endcase
  endtask

  task automatic set_divisor(input logic [15:0] v);
    s_tvalid <= 1'b0;
    wait (flow_queue.size() == 0);
    repeat (1100) @(posedge clk);
    cfg_we    <= 1'b1;
    cfg_wdata <= v;
    @(posedge clk);
    cfg_we <= 1'b0;
    divisor = v;
  endtask

  always @(posedge clk) begin
    if (!rst && m_tvalid && m_tready) begin
      if (flow_queue.size() == 0) begin
        report("unexpected result", m_tdata[20:0], '0);
      end else if (m_tdata[20:0] !== flow_queue[0]) begin
        report("max_flow", m_tdata[20:0], flow_queue.pop_front());
      end else begin
        void'(flow_queue.pop_front());
      end
    end
  end

  initial begin
    m_tready = 1'b0;
    forever begin
      @(posedge clk);
      if (hold_req) begin
        m_tready <= 1'b0;
        repeat (60000) @(posedge clk);
        hold_req = 0;
      end else begin
        m_tready <= calm || $urandom_range(99) >= 28;
      end
    end
  end

  initial begin
    #200_000_000;
    $display("tb: failure");
    $finish;
  end

  initial begin
    stim_row_t   rows [$];
    logic [4:0]  nodes [6];
    int          n;
    rst       = 1'b1;
    cfg_we    = 1'b0;
    cfg_wdata = '0;
    s_tvalid  = 1'b0;
    s_tdata   = '0;
    s_tuser   = '0;
    errors    = 0;
    calm      = 0;
    hold_req  = 0;
    runs_sent = 0;
    divisor   = 16'd1;
    foreach (cap_matrix[i, j]) cap_matrix[i][j] = '0;
    repeat (9) @(posedge clk);
    rst <= 1'b0;

    rows = '{
      '{OP_RUN,    5'd0,  5'd1,  16'h0000, 1, 21'd0},
      '{OP_RUN,    5'd3,  5'd3,  16'hffff, 1, 21'd0},
      '{OP_WRITE,  5'd0,  5'd31, 16'hffff, 0, 21'd0},
      '{OP_WRITE,  5'd0,  5'd1,  16'hffff, 0, 21'd0},
      '{OP_WRITE,  5'd1,  5'd31, 16'hffff, 0, 21'd0},
      '{OP_WRITE,  5'd31, 5'd31, 16'hffff, 0, 21'd0},
      '{OP_WRITE,  5'd31, 5'd0,  16'h0000, 0, 21'd0},
      '{OP_UNUSED, 5'd31, 5'd31, 16'hffff, 0, 21'd0},
      '{OP_RUN,    5'd0,  5'd31, 16'h0000, 0, 21'd0},
      '{OP_RUN,    5'd31, 5'd0,  16'h0000, 0, 21'd0},
      '{OP_RUN,    5'd31, 5'd31, 16'h0000, 1, 21'd0},
      '{OP_WRITE,  5'd2,  5'd3,  16'h5555, 0, 21'd0},
      '{OP_WRITE,  5'd3,  5'd2,  16'haaaa, 0, 21'd0},
      '{OP_RUN,    5'd2,  5'd3,  16'h0000, 0, 21'd0},
      '{OP_CLEAR,  5'd31, 5'd31, 16'hffff, 0, 21'd0},
      '{OP_RUN,    5'd0,  5'd31, 16'h0000, 1, 21'd0}
    };
    calm = 1;
    foreach (rows[i]) begin
      if (i == 8) calm = 0;
      send(rows[i].op, rows[i].from_node, rows[i].to_node, rows[i].cap,
           rows[i].typed, rows[i].flow);
    end

    // zero divisor gives no flow at all
    set_divisor(16'd0);
    send(OP_WRITE, 5'd4, 5'd5, 16'hffff);
    send(OP_RUN, 5'd4, 5'd5, 16'h0, 1, 21'd0);
    set_divisor(16'hffff);
    send(OP_WRITE, 5'd5, 5'd6, 16'hfffe);
    send(OP_RUN, 5'd4, 5'd5, 16'h0, 1, 21'd1);
    send(OP_RUN, 5'd4, 5'd6, 16'h0);

    // long output stall while loads and runs pile up
    hold_req = 1;
    send(OP_RUN, 5'd4, 5'd5, 16'h0);
    send(OP_RUN, 5'd5, 5'd6, 16'h0);
    send(OP_WRITE, 5'd7, 5'd8, 16'h1234);
    send(OP_RUN, 5'd7, 5'd8, 16'h0);

    while (runs_sent < 25) begin
      set_divisor(16'($urandom_range(1, 5)));
      calm = (runs_sent > 15 && runs_sent < 20);
      foreach (nodes[i]) nodes[i] = 5'($urandom_range(31));
      if ($urandom_range(3) != 0) send(OP_CLEAR, 5'($urandom), 5'($urandom), 16'($urandom));
      n = $urandom_range(2, 9);
      repeat (n) begin
        case ($urandom_range(9))
          0: send(OP_UNUSED, 5'($urandom), 5'($urandom), 16'($urandom));
          1: send(OP_WRITE, 5'($urandom), 5'($urandom), 16'($urandom));
          default: send(OP_WRITE, nodes[$urandom_range(5)], nodes[$urandom_range(5)],
                        $urandom_range(1) ? 16'($urandom) : 16'($urandom_range(20)));
        endcase
      end
      send(OP_RUN, nodes[$urandom_range(5)], nodes[$urandom_range(5)], 16'($urandom));
      if ($urandom_range(2) == 0)
        send(OP_RUN, nodes[$urandom_range(5)], nodes[$urandom_range(5)], 16'($urandom));
    end

    s_tvalid <= 1'b0;
    wait (flow_queue.size() == 0);
    repeat (2000) @(posedge clk);
    if (errors == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

endmodule
